>>> rtl/rsi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_pkg
// widths, limits and stage record types shared by the ray-sphere test
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int CW      = 32;           // coordinate width
    localparam int FRAC    = 16;           // fraction bits
    localparam int OC_W    = CW + 1;       // origin minus center
    localparam int A_W     = 2 * CW;       // a = dir.dir, unsigned
    localparam int H_W     = 2 * CW + 2;   // h = oc.dir, signed
    localparam int C_W     = 2 * CW + 3;   // c = oc.oc - r*r, signed
    localparam int D_W     = 4 * CW + 6;   // discriminant h*h - a*c, signed, even
    localparam int S_W     = D_W / 2;      // square root width
    localparam int NUM_W   = S_W + 1;      // -h - sqrt(d), signed
    localparam int MAG_W   = NUM_W + FRAC; // scaled numerator magnitude
    localparam int Q_W     = CW + 1;       // quotient bits kept
    localparam int MUL_W   = 2 * CW + 4;   // multiplier operand width
    localparam int LIMB    = MUL_W / 2;    // partial product limb
    localparam int P_W     = 2 * MUL_W;    // product width
    localparam int MUL_LAT = 4;            // multiplier latency

    localparam logic [CW-1:0] T_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] T_MIN = {1'b1, {(CW-1){1'b0}}};

    // square root cell data
    typedef struct packed {
        logic [D_W-1:0] rad;
        logic [S_W:0]   rem;
        logic [S_W-1:0] root;
    } sq_t;

    // data riding along the square root chain
    typedef struct packed {
        logic                  valid;
        logic                  nohit;
        logic signed [H_W-1:0] h;
        logic [A_W-1:0]        a;
    } sd_t;

    // division cell data
    typedef struct packed {
        logic           valid;
        logic           nohit;
        logic           neg;
        logic           ovf;
        logic [A_W-1:0] rem;
        logic [A_W-1:0] a;
        logic [Q_W-1:0] low;
        logic [Q_W-1:0] q;
    } dv_t;

endpackage
`default_nettype wire

>>> rtl/rsi_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_mul
// pipelined signed multiplier, four limb products; registered magnitude, limb product, sum and sign steps
// ----------------------------------------------------------------------------
module rsi_mul import rsi_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [MUL_W-1:0] op_a,
    input  wire logic signed [MUL_W-1:0] op_b,
    output logic signed [P_W-1:0]      prod
);

    logic [MUL_W-1:0]  ma_reg, mb_reg;
    logic              sg1_reg, sg2_reg, sg3_reg;
    logic [2*LIMB-1:0] pp_reg [4];
    logic [P_W-1:0]    sum_reg;
    logic signed [P_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // magnitudes
            ma_reg  <= op_a[MUL_W-1] ? -op_a : op_a;
            mb_reg  <= op_b[MUL_W-1] ? -op_b : op_b;
            sg1_reg <= op_a[MUL_W-1] ^ op_b[MUL_W-1];
            // limb products
            pp_reg[0] <= ma_reg[LIMB-1:0] * mb_reg[LIMB-1:0];
            pp_reg[1] <= ma_reg[LIMB-1:0] * mb_reg[MUL_W-1:LIMB];
            pp_reg[2] <= ma_reg[MUL_W-1:LIMB] * mb_reg[LIMB-1:0];
            pp_reg[3] <= ma_reg[MUL_W-1:LIMB] * mb_reg[MUL_W-1:LIMB];
            sg2_reg   <= sg1_reg;
            // combine
            sum_reg <= P_W'(pp_reg[0]) + (P_W'(pp_reg[1]) << LIMB)
                     + (P_W'(pp_reg[2]) << LIMB) + (P_W'(pp_reg[3]) << (2 * LIMB));
            sg3_reg <= sg2_reg;
            // apply sign
            prod_reg <= sg3_reg ? -sum_reg : sum_reg;
        end
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

>>> rtl/rsi_sqrt_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_sqrt_cell
// one root bit of a restoring integer square root
// ----------------------------------------------------------------------------
module rsi_sqrt_cell import rsi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire sq_t  sq_in,
    input  wire sd_t  sd_in,
    output sq_t       sq_out,
    output sd_t       sd_out
);

    logic [S_W+2:0] remx, trial, diff;
    logic           ge;
    sq_t            sq_next;
    sq_t            sq_reg;
    sd_t            sd_reg;
    logic           valid_reg;

    always_comb begin
        remx  = {sq_in.rem, sq_in.rad[D_W-1 -: 2]};
        trial = {1'b0, sq_in.root, 2'b01};
        diff  = remx - trial;
        ge    = (remx >= trial);
        sq_next.rem  = ge ? diff[S_W:0] : remx[S_W:0];
        sq_next.root = {sq_in.root[S_W-2:0], ge};
        sq_next.rad  = {sq_in.rad[D_W-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= sd_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg <= sq_next;
            sd_reg <= sd_in;
        end
    end

    always_comb begin
        sq_out       = sq_reg;
        sd_out       = sd_reg;
        sd_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

>>> rtl/rsi_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_div_cell
// one quotient bit of a restoring unsigned division
// ----------------------------------------------------------------------------
module rsi_div_cell import rsi_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire dv_t  dv_in,
    output dv_t       dv_out
);

    logic [A_W:0] remx, diff;
    logic         ge;
    dv_t          dv_next;
    dv_t          dv_reg;
    logic         valid_reg;

    always_comb begin
        remx    = {dv_in.rem, dv_in.low[Q_W-1]};
        diff    = remx - {1'b0, dv_in.a};
        ge      = (remx >= {1'b0, dv_in.a});
        dv_next = dv_in;
        dv_next.rem = ge ? diff[A_W-1:0] : remx[A_W-1:0];
        dv_next.low = {dv_in.low[Q_W-2:0], 1'b0};
        dv_next.q   = {dv_in.q[Q_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= dv_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_reg <= dv_next;
        end
    end

    always_comb begin
        dv_out       = dv_reg;
        dv_out.valid = valid_reg;
    end

endmodule
`default_nettype wire

>>> rtl/ray_sphere_intersection.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ray_sphere_intersection
// streaming ray-sphere test, signed Q15.16, near root with saturation
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_*      | in  | s_valid / s_ready   | origin, dir, center, sphere_radius
//  m_*      | out | m_valid / m_ready   | hit, distance, saturated
//
//  one beat accepted per cycle while the pipeline is not held
//  the path runs through the 67-cell square root chain and the 33-cell divide chain
//  the whole pipeline advances together; it holds only while a result waits
//  on m_ready, and s_ready follows that same enable
//  aresetn clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
module ray_sphere_intersection import rsi_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic signed [CW-1:0] s_origin_x,
    input  wire logic signed [CW-1:0] s_origin_y,
    input  wire logic signed [CW-1:0] s_origin_z,
    input  wire logic signed [CW-1:0] s_dir_x,
    input  wire logic signed [CW-1:0] s_dir_y,
    input  wire logic signed [CW-1:0] s_dir_z,
    input  wire logic signed [CW-1:0] s_center_x,
    input  wire logic signed [CW-1:0] s_center_y,
    input  wire logic signed [CW-1:0] s_center_z,
    input  wire logic [CW-2:0]        s_sphere_radius,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    output logic signed [CW-1:0]      m_distance,
    output logic                      m_saturated
);

    // pipeline enable: move unless the output beat is stuck
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage 1: oc = origin - center
    logic signed [CW-1:0]   org [3], dir [3], ctr [3];
    logic signed [OC_W-1:0] oc_reg [3];
    logic signed [CW-1:0]   d_reg [3];
    logic [CW-2:0]          r_reg;
    logic                   v1_reg;

    always_comb begin
        org[0] = s_origin_x; org[1] = s_origin_y; org[2] = s_origin_z;
        dir[0] = s_dir_x;    dir[1] = s_dir_y;    dir[2] = s_dir_z;
        ctr[0] = s_center_x; ctr[1] = s_center_y; ctr[2] = s_center_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                oc_reg[i] <= {org[i][CW-1], org[i]} - {ctr[i][CW-1], ctr[i]};
                d_reg[i]  <= dir[i];
            end
            r_reg <= s_sphere_radius;
        end
    end

    // first products: dir*dir, oc*dir, oc*oc, r*r
    logic signed [MUL_W-1:0] ocx [3], dx [3];
    logic signed [MUL_W-1:0] rx;
    logic signed [P_W-1:0]   pdd [3], pod [3], poo [3];
    logic signed [P_W-1:0]   prr;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ocx[i] = {{(MUL_W-OC_W){oc_reg[i][OC_W-1]}}, oc_reg[i]};
            dx[i]  = {{(MUL_W-CW){d_reg[i][CW-1]}}, d_reg[i]};
        end
        rx = {{(MUL_W-CW+1){1'b0}}, r_reg};
    end

    for (genvar g = 0; g < 3; g++) begin : g_mul1
        rsi_mul u_dd (.aclk(aclk), .en(en), .op_a(dx[g]),  .op_b(dx[g]), .prod(pdd[g]));
        rsi_mul u_od (.aclk(aclk), .en(en), .op_a(ocx[g]), .op_b(dx[g]), .prod(pod[g]));
        rsi_mul u_oo (.aclk(aclk), .en(en), .op_a(ocx[g]), .op_b(ocx[g]), .prod(poo[g]));
    end
    rsi_mul u_rr (.aclk(aclk), .en(en), .op_a(rx), .op_b(rx), .prod(prr));

    logic vm_reg [MUL_LAT];

    // stage 2: a, h, c
    logic [A_W-1:0]        a2_reg;
    logic signed [H_W-1:0] h2_reg;
    logic signed [C_W-1:0] c2_reg;
    logic                  v2_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg <= pdd[0][A_W-1:0] + pdd[1][A_W-1:0] + pdd[2][A_W-1:0];
            h2_reg <= pod[0][H_W-1:0] + pod[1][H_W-1:0] + pod[2][H_W-1:0];
            c2_reg <= poo[0][C_W-1:0] + poo[1][C_W-1:0] + poo[2][C_W-1:0]
                    - prr[C_W-1:0];
        end
    end

    // second products: h*h and a*c
    logic signed [MUL_W-1:0] hx, ax, cx;
    logic signed [P_W-1:0]   phh, pac;

    assign hx = {{(MUL_W-H_W){h2_reg[H_W-1]}}, h2_reg};
    assign ax = {{(MUL_W-A_W){1'b0}}, a2_reg};
    assign cx = {{(MUL_W-C_W){c2_reg[C_W-1]}}, c2_reg};

    rsi_mul u_hh (.aclk(aclk), .en(en), .op_a(hx), .op_b(hx), .prod(phh));
    rsi_mul u_ac (.aclk(aclk), .en(en), .op_a(ax), .op_b(cx), .prod(pac));

    // a and h wait alongside the second products
    logic [A_W-1:0]        ad_reg [MUL_LAT];
    logic signed [H_W-1:0] hd_reg [MUL_LAT];
    logic                  vd_reg [MUL_LAT];

    always_ff @(posedge aclk) begin
        if (en) begin
            ad_reg[0] <= a2_reg;
            hd_reg[0] <= h2_reg;
            for (int i = 1; i < MUL_LAT; i++) begin
                ad_reg[i] <= ad_reg[i-1];
                hd_reg[i] <= hd_reg[i-1];
            end
        end
    end

    // stage 3: discriminant and no-hit test
    logic [D_W-1:0] disc;
    sq_t            sq3_reg;
    sd_t            sd3_reg;
    logic           v3_reg;

    assign disc = phh[D_W-1:0] - pac[D_W-1:0];

    always_ff @(posedge aclk) begin
        if (en) begin
            sq3_reg.rad   <= disc;
            sq3_reg.rem   <= '0;
            sq3_reg.root  <= '0;
            sd3_reg.valid <= 1'b0;
            sd3_reg.nohit <= (ad_reg[MUL_LAT-1] == '0) || disc[D_W-1];
            sd3_reg.h     <= hd_reg[MUL_LAT-1];
            sd3_reg.a     <= ad_reg[MUL_LAT-1];
        end
    end

    // square root chain, one root bit per cell
    sq_t sq_c [S_W+1];
    sd_t sd_c [S_W+1];

    always_comb begin
        sq_c[0]       = sq3_reg;
        sd_c[0]       = sd3_reg;
        sd_c[0].valid = v3_reg;
    end

    for (genvar g = 0; g < S_W; g++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .sq_in(sq_c[g]), .sd_in(sd_c[g]),
            .sq_out(sq_c[g+1]), .sd_out(sd_c[g+1])
        );
    end

    // stage 4: num = -h - sqrt(d)
    logic signed [NUM_W-1:0] num4_reg;
    logic [A_W-1:0]          a4_reg;
    logic                    nh4_reg, v4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num4_reg <= -{{(NUM_W-H_W){sd_c[S_W].h[H_W-1]}}, sd_c[S_W].h}
                      - {1'b0, sq_c[S_W].root};
            a4_reg   <= sd_c[S_W].a;
            nh4_reg  <= sd_c[S_W].nohit;
        end
    end

    // stage 5: scaled magnitude and sign
    logic [NUM_W-1:0] nabs;
    logic [MAG_W-1:0] mag5_reg;
    logic [A_W-1:0]   a5_reg;
    logic             neg5_reg, nh5_reg, v5_reg;

    assign nabs = num4_reg[NUM_W-1] ? -num4_reg : num4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            mag5_reg <= {nabs, {FRAC{1'b0}}};
            neg5_reg <= num4_reg[NUM_W-1];
            a5_reg   <= a4_reg;
            nh5_reg  <= nh4_reg;
        end
    end

    // stage 6: quotient overflow check, divider setup
    logic [A_W-1:0] mag_hi;
    dv_t            dv6_reg;
    logic           v6_reg;

    assign mag_hi = A_W'(mag5_reg[MAG_W-1:Q_W]);

    always_ff @(posedge aclk) begin
        if (en) begin
            dv6_reg.valid <= 1'b0;
            dv6_reg.nohit <= nh5_reg;
            dv6_reg.neg   <= neg5_reg;
            dv6_reg.ovf   <= (mag_hi >= a5_reg);
            dv6_reg.rem   <= mag_hi;
            dv6_reg.a     <= a5_reg;
            dv6_reg.low   <= mag5_reg[Q_W-1:0];
            dv6_reg.q     <= '0;
        end
    end

    // divide chain, one quotient bit per cell
    dv_t dv_c [Q_W+1];

    always_comb begin
        dv_c[0]       = dv6_reg;
        dv_c[0].valid = v6_reg;
    end

    for (genvar g = 0; g < Q_W; g++) begin : g_div
        rsi_div_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .dv_in(dv_c[g]), .dv_out(dv_c[g+1])
        );
    end

    // valid bits of the plain stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            for (int i = 0; i < MUL_LAT; i++) begin
                vm_reg[i] <= 1'b0;
                vd_reg[i] <= 1'b0;
            end
        end else if (en) begin
            v1_reg    <= s_valid;
            vm_reg[0] <= v1_reg;
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < MUL_LAT; i++) begin
                vm_reg[i] <= vm_reg[i-1];
                vd_reg[i] <= vd_reg[i-1];
            end
            v2_reg <= vm_reg[MUL_LAT-1];
            v3_reg <= vd_reg[MUL_LAT-1];
            v4_reg <= sd_c[S_W].valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    // output stage: floor rounding, clamp, no-hit zeroing
    dv_t             dvo;
    logic [Q_W:0]    qn;
    logic            sat;
    logic [CW-1:0]   t;
    logic            hit_reg, sat_reg;
    logic [CW-1:0]   dist_reg;

    always_comb begin
        dvo = dv_c[Q_W];
        // negative side rounds toward minus infinity
        qn  = {1'b0, dvo.q} + (Q_W+1)'(dvo.neg && (dvo.rem != '0));
        if (dvo.neg) begin
            sat = dvo.ovf || (qn > (Q_W+1)'(T_MIN));
        end else begin
            sat = dvo.ovf || (dvo.q > Q_W'(T_MAX));
        end
        if (sat) begin
            t = dvo.neg ? T_MIN : T_MAX;
        end else if (dvo.neg) begin
            t = -qn[CW-1:0];
        end else begin
            t = dvo.q[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dvo.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg  <= !dvo.nohit;
            sat_reg  <= !dvo.nohit && sat;
            dist_reg <= dvo.nohit ? '0 : t;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_hit       = hit_reg;
    assign m_saturated = sat_reg;
    assign m_distance  = dist_reg;

endmodule
`default_nettype wire

>>> rtl/rsi_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rsi_checker
// port-level checks on the result channel of the ray-sphere test
// ----------------------------------------------------------------------------
module rsi_checker import rsi_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_hit,
    input wire logic signed [CW-1:0] m_distance,
    input wire logic                 m_saturated
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_hit))
        else $error("result beat changed while stalled");

    // input side stalls exactly when a result beat is stuck
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not follow output stall");

    // a miss carries no distance
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_distance == '0 && !m_saturated)
        else $error("miss with nonzero distance or saturation");

    // saturation only to the range ends
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_hit && (m_distance == T_MAX || m_distance == T_MIN))
        else $error("saturated distance is not a range end");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (.*);
`default_nettype wire
